// ----- sv/rau_pkg.sv -----
package rau_pkg;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CMP  = 3'd4,
    OP_NORM = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK   = 2'd0,
    ERR_ZERO = 2'd1,
    ERR_OVF  = 2'd2
  } err_t;

  typedef struct packed {
    logic ge;
    logic zero;
  } alu_flags_t;

endpackage

// ----- sv/rational_arith_unit.sv -----
// Rational arithmetic unit: add, subtract, multiply, divide, compare or
// normalize signed fractions, result reduced to lowest terms.
// Input channel s_axis: tuser carries the opcode, tdata the four operands
// a_num, a_den, b_num, b_den. Output channel m_axis: tdata carries res_num,
// res_den, less, equal, greater and error.
// One transaction is in flight at a time; s_axis_tready is high only while
// the sequencer is idle. Operand errors and unused opcodes go from the setup
// state straight to the output state; compare passes through the product and
// compare states first. Arithmetic results take products on one registered
// WIDTH x WIDTH multiplier (normalize skips them), for add and subtract an add
// step (after a swap when the magnitudes call for it), a binary gcd on
// 2*WIDTH-bit values (one subtract, swap or shift per cycle) and two restoring
// divisions by the gcd; the add, compare, gcd and division steps share one
// (2*WIDTH+1)-bit adder.
// The result sits in an output register; the next input is accepted while
// it waits, and a new result stalls in the sequencer until m_axis_tready
// frees the register.
// Reset (rst, synchronous) returns the sequencer to idle and drops any
// pending output.
module rational_arith_unit #(
  parameter int WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // a_num, a_den, b_num, b_den
  input  logic [2:0]   s_axis_tuser,  // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata   // res_num, res_den, less, equal, greater, error
);
  import rau_pkg::*;

  localparam int DW = 2 * WIDTH;
  localparam int AW = DW + 1;
  localparam int KW = $clog2(DW + 1);
  localparam int CW = $clog2(DW);
  localparam logic [DW-1:0] LIM = DW'(1) << (WIDTH - 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SETUP = 11'b00000000010,
    S_MUL   = 11'b00000000100,
    S_MULW  = 11'b00000001000,
    S_ADD   = 11'b00000010000,
    S_CMP   = 11'b00000100000,
    S_PREP  = 11'b00001000000,
    S_GCD   = 11'b00010000000,
    S_DIV   = 11'b00100000000,
    S_FIN   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state;

  function automatic logic [WIDTH-1:0] fmag(input logic [WIDTH-1:0] v);
    fmag = v[WIDTH-1] ? -v : v;
  endfunction

  logic [2:0]       op;
  logic [WIDTH-1:0] an, ad, bn, bd;
  logic             an_neg, bn_neg;
  logic [DW-1:0]    x, y, dn, gx, gy, g, rem, dq, qn;
  logic             xneg, yneg, phase;
  logic [1:0]       mk;
  logic [KW-1:0]    k;
  logic [CW-1:0]    cnt;
  logic [31:0]      r_num;
  logic [30:0]      r_den;
  logic             r_lt, r_eq, r_gt;
  err_t             r_err;

  logic [WIDTH-1:0] mul_a, mul_b;
  logic [DW-1:0]    prod;
  logic             alu_sub;
  logic [AW-1:0]    alu_a, alu_b, alu_res;
  alu_flags_t       alu_f;

  logic [WIDTH-1:0] in_an, in_ad, in_bn, in_bd;
  logic [1:0]       mk_last;
  logic [DW-1:0]    dq_sh, rem_n;
  logic [AW-1:0]    div_a;
  logic             ovf, sx, sy;
  logic [WIDTH-1:0] nv;

  rau_mul #(.W(WIDTH)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  rau_alu #(.AW(AW)) u_alu (
    .sub   (alu_sub),
    .a     (alu_a),
    .b     (alu_b),
    .res   (alu_res),
    .flags (alu_f)
  );

  assign s_axis_tready = (state == S_IDLE);

  assign in_an = s_axis_tdata[WIDTH-1:0];
  assign in_ad = s_axis_tdata[32+WIDTH-1:32];
  assign in_bn = s_axis_tdata[64+WIDTH-1:64];
  assign in_bd = s_axis_tdata[96+WIDTH-1:96];

  always_comb begin
    mul_a = ad;
    mul_b = bd;
    unique case (mk)
      2'd0: begin
        mul_a = an;
        mul_b = (op == OP_MUL) ? bn : bd;
      end
      2'd1: begin
        if (op == OP_MUL) begin
          mul_a = ad;
          mul_b = bd;
        end else if (op == OP_DIV) begin
          mul_a = ad;
          mul_b = bn;
        end else begin
          mul_a = bn;
          mul_b = ad;
        end
      end
      default: begin
        mul_a = ad;
        mul_b = bd;
      end
    endcase
    mk_last = (op == OP_ADD || op == OP_SUB) ? 2'd2 : 2'd1;
  end

  always_comb begin
    div_a   = {rem, dq[DW-1]};
    alu_sub = 1'b1;
    alu_a   = {1'b0, x};
    alu_b   = {1'b0, y};
    unique case (state)
      S_ADD: alu_sub = (xneg != yneg);
      S_GCD: begin
        alu_a = {1'b0, gx};
        alu_b = {1'b0, gy};
      end
      S_DIV: begin
        alu_a = div_a;
        alu_b = {1'b0, g};
      end
      default: alu_sub = 1'b1;
    endcase
    dq_sh = {dq[DW-2:0], alu_f.ge};
    rem_n = alu_f.ge ? alu_res[DW-1:0] : div_a[DW-1:0];
    sx    = xneg && (x != '0);
    sy    = yneg && (y != '0);
    ovf   = (xneg ? (qn > LIM) : (qn > LIM - DW'(1))) || (dq > LIM - DW'(1));
    nv    = xneg ? -qn[WIDTH-1:0] : qn[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op     <= s_axis_tuser;
            an     <= fmag(in_an);
            ad     <= fmag(in_ad);
            bn     <= fmag(in_bn);
            bd     <= fmag(in_bd);
            an_neg <= in_an[WIDTH-1] ^ in_ad[WIDTH-1];
            bn_neg <= in_bn[WIDTH-1] ^ in_bd[WIDTH-1];
            state  <= S_SETUP;
          end
        end
        S_SETUP: begin
          r_num <= '0;
          r_den <= 31'd1;
          r_lt  <= 1'b0;
          r_eq  <= 1'b0;
          r_gt  <= 1'b0;
          mk    <= 2'd0;
          if (op > OP_NORM) begin
            r_err <= ERR_OK;
            state <= S_OUT;
          end else if (op == OP_NORM) begin
            if (ad == '0) begin
              r_err <= ERR_ZERO;
              state <= S_OUT;
            end else begin
              r_err <= ERR_OK;
              x     <= DW'(an);
              xneg  <= an_neg;
              dn    <= DW'(ad);
              state <= S_PREP;
            end
          end else if (ad == '0 || bd == '0 || (op == OP_DIV && bn == '0)) begin
            r_err <= ERR_ZERO;
            state <= S_OUT;
          end else begin
            r_err <= ERR_OK;
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_MULW;
        S_MULW: begin
          unique case (mk)
            2'd0: x <= prod;
            2'd1: begin
              if (op == OP_MUL || op == OP_DIV) begin
                dn <= prod;
              end else begin
                y <= prod;
              end
            end
            default: dn <= prod;
          endcase
          if (mk == mk_last) begin
            priority if (op == OP_ADD || op == OP_SUB) begin
              xneg  <= an_neg;
              yneg  <= bn_neg ^ (op == OP_SUB);
              state <= S_ADD;
            end else if (op == OP_CMP) begin
              xneg  <= an_neg;
              yneg  <= bn_neg;
              state <= S_CMP;
            end else begin
              xneg  <= an_neg ^ bn_neg;
              state <= S_PREP;
            end
          end else begin
            mk    <= mk + 2'd1;
            state <= S_MUL;
          end
        end
        S_ADD: begin
          if (xneg == yneg || alu_f.ge) begin
            x     <= alu_res[DW-1:0];
            state <= S_PREP;
          end else begin
            x    <= y;
            y    <= x;
            xneg <= yneg;
            yneg <= xneg;
          end
        end
        S_CMP: begin
          if (sx != sy) begin
            r_lt <= sx;
            r_gt <= sy;
          end else begin
            r_eq <= alu_f.zero;
            r_lt <= sx ? (alu_f.ge && !alu_f.zero) : !alu_f.ge;
            r_gt <= sx ? !alu_f.ge : (alu_f.ge && !alu_f.zero);
          end
          state <= S_OUT;
        end
        S_PREP: begin
          if (x == '0) begin
            qn    <= '0;
            dq    <= DW'(1);
            xneg  <= 1'b0;
            state <= S_FIN;
          end else begin
            gx    <= x;
            gy    <= dn;
            k     <= '0;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          priority if (alu_f.zero) begin
            g     <= gx << k;
            rem   <= '0;
            dq    <= x;
            cnt   <= '0;
            phase <= 1'b0;
            state <= S_DIV;
          end else if (!gx[0] && !gy[0]) begin
            gx <= gx >> 1;
            gy <= gy >> 1;
            k  <= k + KW'(1);
          end else if (!gx[0]) begin
            gx <= gx >> 1;
          end else if (!gy[0]) begin
            gy <= gy >> 1;
          end else if (alu_f.ge) begin
            gx <= alu_res[DW-1:0];
          end else begin
            gx <= gy;
            gy <= gx;
          end
        end
        S_DIV: begin
          if (cnt == CW'(DW - 1) && !phase) begin
            qn    <= dq_sh;
            dq    <= dn;
            rem   <= '0;
            cnt   <= '0;
            phase <= 1'b1;
          end else begin
            rem <= rem_n;
            dq  <= dq_sh;
            cnt <= cnt + CW'(1);
            if (cnt == CW'(DW - 1)) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (ovf) begin
            r_err <= ERR_OVF;
          end else begin
            r_num <= 32'(signed'(nv));
            r_den <= 31'(dq);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata <= {4'd0, r_err, r_gt, r_eq, r_lt, r_den, r_num};
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_err_zero_result: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[67:66] != ERR_OK) |->
      (m_axis_tdata[31:0] == 32'd0 && m_axis_tdata[62:32] == 31'd1))
    else $error("error result is not 0/1");

  a_flags_onehot0: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[65:63]))
    else $error("more than one compare flag set");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[62:32] != 31'd0))
    else $error("zero denominator on output");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready held after accept");
`endif

endmodule

// ----- sv/rau_mul.sv -----
module rau_mul #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ----- sv/rau_alu.sv -----
module rau_alu #(
  parameter int AW = 65
) (
  input  logic                  sub,
  input  logic [AW-1:0]         a,
  input  logic [AW-1:0]         b,
  output logic [AW-1:0]         res,
  output rau_pkg::alu_flags_t   flags
);
  import rau_pkg::*;

  logic [AW:0] ext;

  always_comb begin
    ext        = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (AW+1)'(sub);
    res        = ext[AW-1:0];
    flags.ge   = ext[AW];
    flags.zero = (ext[AW-1:0] == '0);
  end

endmodule
